FILE: design/bmt_pkg.sv
// ============================================================================
// bmt_pkg
// Shared types, constants and helpers of the breakpoint match table.
// ============================================================================
package bmt_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int TABLE_COUNT = 2;

  localparam int ADDR_W = 16;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int TBL_W  = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
  localparam int OUT_CNT_W = 5;

  // Result action codes
  localparam logic [1:0] ACT_LOOKUP  = 2'd0;
  localparam logic [1:0] ACT_ADDED   = 2'd1;
  localparam logic [1:0] ACT_REMOVED = 2'd2;
  localparam logic [1:0] ACT_FULL    = 2'd3;

  // Command broadcast to every cell of the row
  typedef struct packed {
    logic              toggle;  // update cycle of a toggle on a valid table
    logic [TBL_W-1:0]  tbl;     // selected table
    logic [ADDR_W-1:0] addr;    // address under test
  } bmt_cmd_t;

  // Fit an internal count into the 5-bit result field
  function automatic logic [OUT_CNT_W-1:0] to_count5(input logic [CNT_W-1:0] c);
    logic [CNT_W+OUT_CNT_W-1:0] tmp;
    tmp = '0;
    tmp[CNT_W-1:0] = c;
    return tmp[OUT_CNT_W-1:0];
  endfunction

endpackage

FILE: design/bmt_cell.sv
// ============================================================================
// bmt_cell
// One slot of the breakpoint row: holds entry i of every table, compares it
// against the address, and shifts in its upper neighbor's entry on removal.
// ============================================================================
module bmt_cell
  import bmt_pkg::*;
(
  input  logic              clk,
  input  bmt_cmd_t          cmd,
  input  logic              valid,      // slot lies below the table's count
  input  logic              append,     // write the address into this slot
  input  logic              hit_in,     // a match was seen in a lower slot
  input  logic [ADDR_W-1:0] entry_in,   // upper neighbor's entry
  output logic              hit_out,    // match seen here or below
  output logic [ADDR_W-1:0] entry_out   // this slot's entry of the table
);

  logic [ADDR_W-1:0] ent [TABLE_COUNT];
  logic              match;

  // Compare against the selected table's entry
  assign entry_out = ent[cmd.tbl];
  assign match     = valid && (entry_out == cmd.addr);
  assign hit_out   = hit_in | match;

  // Append, or close the gap left by a removed entry
  always_ff @(posedge clk) begin
    if (append) begin
      ent[cmd.tbl] <= cmd.addr;
    end else if (cmd.toggle && hit_out) begin
      ent[cmd.tbl] <= entry_in;
    end
  end

endmodule

FILE: design/breakpoint_match_table_unit.sv
// ============================================================================
// breakpoint_match_table_unit
// Per-CPU compacted breakpoint address tables with lookup and toggle.
// ============================================================================
// Result is registered in the execute state once the output is free.
// A new transaction is taken only while the sequencer is idle: it is accepted
//   there, then compared and shifted through the cell row in the execute state.
// A stalled result holds the sequencer in its execute state, which holds off
//   the next accept; it never drops or reorders a transaction.
// Reset clears the entry counts and the control state; stored entries are
//   left as they are, since only entries below the count are ever matched.
module breakpoint_match_table_unit
  import bmt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] address
  input  logic [1:0]  s_tuser,   // [0] func, [1] table_select
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [0] present, [2:1] action, [7:3] entry_count
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic              state;
  logic              func_q;
  logic              sel_q;
  logic [ADDR_W-1:0] addr_q;
  logic [CNT_W-1:0]  counts [TABLE_COUNT];

  logic              fire;
  logic              in_range;
  logic [TBL_W-1:0]  tbl;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  logic              full;
  logic              present;
  logic              do_add;
  logic [1:0]        action;
  bmt_cmd_t          cmd;

  logic [TABLE_DEPTH-1:0] valid_v;
  logic [TABLE_DEPTH-1:0] append_v;
  logic [TABLE_DEPTH:0]   hit_c;
  logic [ADDR_W-1:0]      entry_c [TABLE_DEPTH+1];

  assign s_tready = (state == ST_IDLE);
  assign fire     = (state == ST_EXEC) && (!m_tvalid || m_tready);

  // Selected table and its count
  assign in_range = (32'(sel_q) < TABLE_COUNT);
  assign tbl      = TBL_W'(sel_q);
  assign cnt      = in_range ? counts[tbl] : '0;
  assign full     = (cnt == CNT_W'(TABLE_DEPTH));

  assign cmd.toggle = fire && func_q && in_range;
  assign cmd.tbl    = tbl;
  assign cmd.addr   = addr_q;

  // Row of cells; the match chain runs from slot 0 upward
  assign hit_c[0]                = 1'b0;
  assign entry_c[TABLE_DEPTH]    = addr_q;
  assign present                 = hit_c[TABLE_DEPTH];
  assign do_add                  = cmd.toggle && !present && !full;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    assign valid_v[i]  = in_range && (cnt > CNT_W'(i));
    assign append_v[i] = do_add && (cnt == CNT_W'(i));

    bmt_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .valid     (valid_v[i]),
      .append    (append_v[i]),
      .hit_in    (hit_c[i]),
      .entry_in  (entry_c[i+1]),
      .hit_out   (hit_c[i+1]),
      .entry_out (entry_c[i])
    );
  end

  // Result code and new count
  always_comb begin
    action   = ACT_LOOKUP;
    cnt_next = cnt;
    if (func_q) begin
      if (!in_range) begin
        action = ACT_FULL;
      end else if (present) begin
        action   = ACT_REMOVED;
        cnt_next = cnt - CNT_W'(1);
      end else if (full) begin
        action = ACT_FULL;
      end else begin
        action   = ACT_ADDED;
        cnt_next = cnt + CNT_W'(1);
      end
    end
  end

  // Sequencer and count registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      for (int t = 0; t < TABLE_COUNT; t++) begin
        counts[t] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (fire) begin
            state <= ST_IDLE;
            if (cmd.toggle) begin
              counts[tbl] <= cnt_next;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Input capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      func_q <= s_tuser[0];
      sel_q  <= s_tuser[1];
      addr_q <= s_tdata;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {to_count5(cnt_next), action, present};
    end
  end

endmodule
